// ----- src/rvd_pkg.sv -----
// Shared command and status codes for the reversible deque.
package rvd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_REVERSE    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_POPPED   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned EXT_W = 64;

  function automatic logic [EXT_W-1:0] sext_in(input logic [IN_W-1:0] v);
    sext_in = {{(EXT_W-IN_W){v[IN_W-1]}}, v};
  endfunction

endpackage

// ----- src/rvd_mem.sv -----
// Single-port ring store with registered read data.
module rvd_mem import rvd_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/rvd_ctrl.sv -----
// Pointer, count and orientation control for the reversible deque.
module rvd_ctrl import rvd_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(DEPTH),
  parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [2:0]            cmd,
  input  logic [IN_W-1:0]       value,
  output logic                  mem_we,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  input  logic [DATA_WIDTH-1:0] mem_rdata,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  output logic [1:0]            out_status,
  output logic [CW-1:0]         out_occupancy
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(DEPTH);

  logic [AW-1:0] first_r, first_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          valid_r;
  logic          pop_ok_r, pop_ok_nxt;
  status_t       status_r, status_nxt;

  logic          high_end;
  logic [CW:0]   sum_tail, sum_last;
  logic [AW-1:0] slot_tail, slot_last;
  logic [EXT_W-1:0] value_ext;

  function automatic logic [EXT_W-1:0] sext_word(input logic [DATA_WIDTH-1:0] w);
    logic [EXT_W-1:0] r;
    for (int i = 0; i < EXT_W; i++) begin
      r[i] = (i < DATA_WIDTH) ? w[i] : w[DATA_WIDTH-1];
    end
    return r;
  endfunction

  assign value_ext = sext_in(value);
  assign sum_tail  = (CW + 1)'(first_r) + (CW + 1)'(count_r);
  assign sum_last  = sum_tail - (CW + 1)'(1);
  assign slot_tail = (sum_tail >= DEPTH_X) ? AW'(sum_tail - DEPTH_X) : AW'(sum_tail);
  assign slot_last = (sum_last >= DEPTH_X) ? AW'(sum_last - DEPTH_X) : AW'(sum_last);

  always_comb begin
    first_nxt  = first_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    pop_ok_nxt = 1'b0;
    status_nxt = ST_ACCEPTED;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = first_r;
    mem_wdata  = value_ext[DATA_WIDTH-1:0];
    high_end   = (cmd == CMD_PUSH_BACK || cmd == CMD_POP_BACK) ? !rev_r : rev_r;
    if (accept) begin
      case (cmd_t'(cmd))
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (count_r == FULL_CNT) begin
            status_nxt = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (high_end) begin
              mem_addr = slot_tail;
            end else begin
              first_nxt = (first_r == '0) ? LAST_SLOT : first_r - AW'(1);
              mem_addr  = first_nxt;
            end
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            mem_re     = 1'b1;
            pop_ok_nxt = 1'b1;
            status_nxt = ST_POPPED;
            count_nxt  = count_r - CW'(1);
            if (high_end) begin
              mem_addr = slot_last;
            end else begin
              mem_addr  = first_r;
              first_nxt = (first_r == LAST_SLOT) ? '0 : first_r + AW'(1);
            end
          end
        end
        CMD_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
          status_nxt = ST_ACCEPTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      count_r  <= '0;
      rev_r    <= 1'b0;
      valid_r  <= 1'b0;
      pop_ok_r <= 1'b0;
    end else begin
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      rev_r    <= rev_nxt;
      valid_r  <= accept;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  logic [EXT_W-1:0] rdata_ext;
  assign rdata_ext = sext_word(mem_rdata);

  assign out_valid     = valid_r;
  assign out_data      = pop_ok_r ? rdata_ext[OUT_W-1:0] : '0;
  assign out_status    = status_r;
  assign out_occupancy = count_r;

endmodule

// ----- src/reversible_deque_top.sv -----
// Top level of the reversible deque: control plus ring store.
// Every request yields one result strobe in the cycle after it is taken.
// Throughput: 1 request per cycle; busy stays low, since a pop reads the single-port
// store in the cycle it is taken and a push writes it, so no two accesses overlap.
// Reset (synchronous, active low) empties the deque and restores normal orientation;
// store contents are not cleared. The receiver cannot stall the result strobe.
module reversible_deque_top import rvd_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     in_cmd,
  input  logic signed [IN_W-1:0]         in_value,
  output logic                           out_valid,
  output logic signed [OUT_W-1:0]        out_data,
  output logic [1:0]                     out_status,
  output logic [$clog2(DEPTH + 1)-1:0]   out_occupancy
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rvd_ctrl #(
    .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .AW(AW), .CW(CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .cmd           (in_cmd),
    .value         (in_value),
    .mem_we        (mem_we),
    .mem_re        (mem_re),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  rvd_mem #(
    .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .AW(AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ----- src/rvd_checker.sv -----
// Port-level checks for the reversible deque, bound to the top level.
module rvd_checker import rvd_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [OUT_W-1:0]             out_data,
  input logic [1:0]                   out_status,
  input logic [$clog2(DEPTH + 1)-1:0] out_occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request without result strobe");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_POPPED) |-> (out_data == '0))
    else $error("nonzero data without a pop");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == CW'(DEPTH)))
    else $error("full status below capacity");

  a_pop_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_POPPED) |-> (out_occupancy < CW'(DEPTH)))
    else $error("pop left store full");

endmodule

bind reversible_deque_top rvd_checker #(.DEPTH(DEPTH)) u_rvd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_data      (out_data),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the reversible deque: directed, fill/drain and random command runs.
module tb;
  import rvd_pkg::*;

  localparam int DEPTH = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 500;
  localparam logic [2:0] FIRST_SPARE_CMD = CMD_REVERSE + 3'd1;
  localparam logic [2:0] LAST_SPARE_CMD = 3'd7;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] data;
    status_t status;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [2:0] in_cmd = '0;
  logic signed [IN_W-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic signed [OUT_W-1:0] out_data;
  logic [1:0] out_status;
  logic [OCC_W-1:0] out_occupancy;

  logic signed [DATA_WIDTH-1:0] deque_mem [DEPTH];
  int head_slot = 0;
  int held = 0;
  bit flipped = 1'b0;

  deque_result_t pending_results [$];
  int errors = 0;
  int stall_cycles = 0;
  int burst_left = 0;

  reversible_deque_top #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_status(out_status),
    .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic status_t push_word(bit high_end, logic signed [DATA_WIDTH-1:0] v);
    if (held >= DEPTH) return ST_FULL;
    if (high_end) begin
      deque_mem[(head_slot + held) % DEPTH] = v;
    end else begin
      head_slot = (head_slot + DEPTH - 1) % DEPTH;
      deque_mem[head_slot] = v;
    end
    held++;
    return ST_ACCEPTED;
  endfunction

  function automatic status_t pop_word(bit high_end, output logic signed [DATA_WIDTH-1:0] v);
    v = '0;
    if (held == 0) return ST_EMPTY;
    if (high_end) begin
      v = deque_mem[(head_slot + held - 1) % DEPTH];
    end else begin
      v = deque_mem[head_slot];
      head_slot = (head_slot + 1) % DEPTH;
    end
    held--;
    return ST_POPPED;
  endfunction

  function automatic deque_result_t deque_step(logic [2:0] cmd, logic signed [IN_W-1:0] value);
    deque_result_t r;
    r.data = '0;
    r.status = ST_ACCEPTED;
    case (cmd)
      CMD_PUSH_BACK:  r.status = push_word(!flipped, value);
      CMD_PUSH_FRONT: r.status = push_word(flipped, value);
      CMD_POP_BACK:   r.status = pop_word(!flipped, r.data);
      CMD_POP_FRONT:  r.status = pop_word(flipped, r.data);
      CMD_REVERSE:    flipped = !flipped;
      default:        r.status = ST_ACCEPTED;
    endcase
    r.occupancy = held[OCC_W-1:0];
    return r;
  endfunction

  task automatic send(input logic [2:0] cmd, input logic signed [IN_W-1:0] value);
    int gap;
    int pick;
    deque_result_t exp_item;
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    exp_item = deque_step(cmd, value);
    pending_results = {pending_results, exp_item};
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) burst_left = $urandom_range(20, 80);
      else if (pick < 55) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %h status %h occ %h",
                 $time, out_data, out_status, out_occupancy);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data !== exp_r.data) flag_mismatch("data", exp_r.data, out_data);
        if (out_status !== exp_r.status) flag_mismatch("status", exp_r.status, out_status);
        if (out_occupancy !== exp_r.occupancy)
          flag_mismatch("occupancy", exp_r.occupancy, out_occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic test_directed();
    send(CMD_POP_BACK, 32'sh1234_5678);
    send(CMD_POP_FRONT, '1);
    send(CMD_REVERSE, '0);
    send(CMD_REVERSE, '0);
    send(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send(CMD_PUSH_BACK, 32'sh8000_0000);
    send(CMD_PUSH_FRONT, '0);
    send(CMD_PUSH_FRONT, '1);
    for (logic [3:0] c = FIRST_SPARE_CMD; c <= LAST_SPARE_CMD; c++) send(c[2:0], 32'shaaaa_aaaa);
    send(CMD_POP_FRONT, '0);
    send(CMD_POP_BACK, '0);
    send(CMD_REVERSE, '0);
    send(CMD_PUSH_BACK, 32'sh0000_0001);
    send(CMD_PUSH_FRONT, 32'sh5555_5555);
    send(CMD_POP_FRONT, '0);
    send(CMD_POP_BACK, '0);
    send(CMD_POP_BACK, '0);
    send(CMD_POP_FRONT, '0);
    send(CMD_POP_FRONT, '0);
    send(CMD_REVERSE, '0);
    hold_until_drained();
  endtask

  task automatic test_random_mix(input int n_items);
    int pick;
    logic [2:0] cmd;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_PUSH_BACK;
      else if (pick < 50) cmd = CMD_PUSH_FRONT;
      else if (pick < 68) cmd = CMD_POP_BACK;
      else if (pick < 86) cmd = CMD_POP_FRONT;
      else if (pick < 96) cmd = CMD_REVERSE;
      else cmd = 3'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
      send(cmd, $urandom);
    end
  endtask

  task automatic test_fill_and_drain();
    int pick;
    while (held < DEPTH) begin
      pick = $urandom_range(0, 99);
      if (pick < 95) send(pick[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
      else if (pick < 98) send(CMD_REVERSE, $urandom);
      else send(pick[0] ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
    end
    send(CMD_PUSH_BACK, $urandom);
    send(CMD_PUSH_FRONT, $urandom);
    send(CMD_REVERSE, $urandom);
    send(CMD_PUSH_BACK, $urandom);
    send(CMD_PUSH_FRONT, $urandom);
    hold_until_drained();
    while (held > DEPTH / 2) begin
      pick = $urandom_range(0, 99);
      if (pick < 95) send(pick[0] ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
      else if (pick < 98) send(CMD_REVERSE, $urandom);
      else send(pick[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
    end
    send(CMD_POP_BACK, $urandom);
    send(CMD_POP_FRONT, $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(80);
    test_fill_and_drain();
    test_random_mix(100);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rvd_pkg.sv
src/rvd_mem.sv
src/rvd_ctrl.sv
src/reversible_deque_top.sv
src/rvd_checker.sv
tb/tb.sv
